>>> src/cadc_pkg.sv
`default_nettype none

package cadc_pkg;

	localparam int ADDR_W   = 32;
	localparam int PREFIX_W = 6;
	localparam int IDX_W    = 4;
	localparam int COUNT_W  = 5;
	localparam int CFG_W    = 5;

	localparam logic [PREFIX_W-1:0] FULL_PREFIX = 6'd32;

	// Input commands.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CHECK = 1'b1;

	// Configuration register indexes.
	localparam logic REG_SECURITY = 1'b0;
	localparam logic REG_RULES    = 1'b1;

	// Rule kinds; any other code is an ignored rule.
	localparam logic [1:0] KIND_ALLOW = 2'd0;
	localparam logic [1:0] KIND_DENY  = 2'd1;

	// Rule actions.
	localparam logic ACTION_PLAY    = 1'b0;
	localparam logic ACTION_PUBLISH = 1'b1;

	// Connection kinds; any other code matches no rule.
	localparam logic [1:0] CONN_PLAY    = 2'd1;
	localparam logic [1:0] CONN_PUBLISH = 2'd2;

	typedef enum logic [1:0] {
		VERDICT_ADMIT       = 2'd0,
		VERDICT_DENY        = 2'd1,
		VERDICT_NOT_ALLOWED = 2'd2,
		VERDICT_WRITTEN     = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic                action;
		logic [ADDR_W-1:0]   network;
		logic [PREFIX_W-1:0] prefix;
	} rule_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] index;
		rule_t            rule;
	} rule_wr_t;

	// Check token that walks the cell row, collecting the decision.
	typedef struct packed {
		logic               valid;
		logic [1:0]         conn;
		logic [ADDR_W-1:0]  addr;
		logic               deny_hit;
		logic [IDX_W-1:0]   deny_at;
		logic               allow_hit;
		logic [IDX_W-1:0]   allow_at;
		logic               has_allow;
		logic               has_deny;
		logic [COUNT_W-1:0] allows;
		logic [COUNT_W-1:0] denies;
	} token_t;

	typedef struct packed {
		verdict_t           verdict;
		logic [IDX_W-1:0]   matched_index;
		logic [COUNT_W-1:0] allow_count;
		logic [COUNT_W-1:0] deny_count;
	} result_t;

	// Network mask for a prefix length; lengths above 32 act as 32.
	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] prefix);
		logic [ADDR_W-1:0] mask;
		if (prefix >= FULL_PREFIX) begin
			mask = '1;
		end else begin
			mask = ~({ADDR_W{1'b1}} >> prefix);
		end
		return mask;
	endfunction

endpackage

`default_nettype wire

>>> src/cadc_if.sv
`default_nettype none

interface cadc_req_if;
	import cadc_pkg::*;
	logic                valid;
	logic                ready;
	logic                command;
	logic [IDX_W-1:0]    rule_index;
	logic [1:0]          rule_kind;
	logic                rule_action;
	logic [ADDR_W-1:0]   rule_network;
	logic [PREFIX_W-1:0] rule_prefix;
	logic [1:0]          conn_kind;
	logic [ADDR_W-1:0]   client_address;

	modport source (
		output valid, command, rule_index, rule_kind, rule_action, rule_network,
		       rule_prefix, conn_kind, client_address,
		input  ready
	);
	modport sink (
		input  valid, command, rule_index, rule_kind, rule_action, rule_network,
		       rule_prefix, conn_kind, client_address,
		output ready
	);
endinterface

interface cadc_rsp_if;
	import cadc_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         verdict;
	logic [IDX_W-1:0]   matched_index;
	logic [COUNT_W-1:0] allow_count;
	logic [COUNT_W-1:0] deny_count;

	modport source (
		output valid, verdict, matched_index, allow_count, deny_count,
		input  ready
	);
	modport sink (
		input  valid, verdict, matched_index, allow_count, deny_count,
		output ready
	);
endinterface

interface cadc_cfg_if;
	import cadc_pkg::*;
	logic             valid;
	logic             ready;
	logic             index;
	logic [CFG_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/cadc_cell.sv
`default_nettype none

module cadc_cell
	import cadc_pkg::*;
#(
	parameter int CELL_INDEX = 0,
	parameter int CNT_W      = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rule_wr_t         wr,
	input  wire token_t           tok_in,
	input  wire logic [CNT_W-1:0] used_in,
	output      token_t           tok_out,
	output      logic [CNT_W-1:0] used_out
);

	localparam logic [IDX_W-1:0] CELL_TAG = IDX_W'(CELL_INDEX);

	rule_t            rule_q;
	token_t           tok_q;
	token_t           tok_next;
	logic [CNT_W-1:0] used_q;
	logic             active;
	logic             applies;
	logic             kind_ok;

	// Rule storage is written only by a rule write addressed to this entry.
	always_ff @(posedge clk) begin
		if (wr.en && (32'(wr.index) == CELL_INDEX)) begin
			rule_q <= wr.rule;
		end
	end

	always_comb begin
		unique case (tok_in.conn)
			CONN_PLAY:    kind_ok = (rule_q.action == ACTION_PLAY);
			CONN_PUBLISH: kind_ok = (rule_q.action == ACTION_PUBLISH);
			default:      kind_ok = 1'b0;
		endcase
		applies = kind_ok
			&& (((rule_q.network ^ tok_in.addr) & prefix_mask(rule_q.prefix)) == '0);
		active  = tok_in.valid && (CNT_W'(CELL_INDEX) < used_in);

		tok_next = tok_in;
		if (active) begin
			unique case (rule_q.kind)
				KIND_DENY: begin
					tok_next.denies   = tok_in.denies + COUNT_W'(1);
					tok_next.has_deny = 1'b1;
					if (!tok_in.deny_hit && applies) begin
						tok_next.deny_hit = 1'b1;
						tok_next.deny_at  = CELL_TAG;
					end
				end
				KIND_ALLOW: begin
					tok_next.allows    = tok_in.allows + COUNT_W'(1);
					tok_next.has_allow = 1'b1;
					if (!tok_in.allow_hit && applies) begin
						tok_next.allow_hit = 1'b1;
						tok_next.allow_at  = CELL_TAG;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= '0;
			used_q <= '0;
		end else begin
			tok_q  <= tok_next;
			used_q <= used_in;
		end
	end

	assign tok_out  = tok_q;
	assign used_out = used_q;

endmodule

`default_nettype wire

>>> src/cidr_allow_deny_checker.sv
// IPv4 CIDR allow/deny checker.
//
// Items arrive on the req channel. A rule write (command 0) stores one rule
// in the entry named by rule_index and returns verdict 3. A check (command 1)
// decides on a client address and connection kind against the first
// rules_in_use entries: first matching deny rule denies, else first matching
// allow rule admits, else the fallback policy applies. Results leave on rsp.
// Configuration registers are written on cfg, which is always ready.
//
// A rule write, or a check with security disabled (always admitted), goes
// from its transfer straight into a holding register and then into the
// output register. A check with security on first walks a row of RULE_DEPTH
// cells, one per cycle, then takes the same path. One item is in flight at a
// time; req is ready again once the result moves into the output register.
//
// Reset clears both configuration registers and all control state; the rule
// table holds garbage until written. When the receiver stalls, the next item
// is still taken, its result waits in a holding register, and req then stays
// not ready until the output register frees.
`default_nettype none

module cidr_allow_deny_checker
	import cadc_pkg::*;
#(
	parameter int RULE_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	cadc_req_if.sink   req,
	cadc_rsp_if.source rsp,
	cadc_cfg_if.sink   cfg
);

	localparam int CNT_W = $clog2(RULE_DEPTH + 1);

	logic             security_q;
	logic [CFG_W-1:0] rules_q;
	logic             busy_q;
	logic             done_valid_q;
	result_t          done_q;
	logic             out_valid_q;
	result_t          out_q;

	logic             accept;
	logic             direct;
	logic [CNT_W-1:0] used_sat;
	rule_wr_t         wr;
	result_t          tail_result;

	token_t           tok  [RULE_DEPTH+1];
	logic [CNT_W-1:0] used [RULE_DEPTH+1];

	// Configuration writes are always taken; users keep them to idle only.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			security_q <= 1'b0;
			rules_q    <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SECURITY: security_q <= cfg.data[0];
				REG_RULES:    rules_q    <= cfg.data;
			endcase
		end
	end

	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;

	// Rule writes and checks with security off skip the cell row entirely.
	assign direct = (req.command == CMD_WRITE) || !security_q;

	// The rules-in-use count saturates at the table depth.
	assign used_sat = (32'(rules_q) > RULE_DEPTH) ? CNT_W'(RULE_DEPTH) : CNT_W'(rules_q);

	// A rule write is broadcast to every cell; only the addressed one keeps it.
	always_comb begin
		wr.en           = accept && (req.command == CMD_WRITE);
		wr.index        = req.rule_index;
		wr.rule.kind    = req.rule_kind;
		wr.rule.action  = req.rule_action;
		wr.rule.network = req.rule_network;
		wr.rule.prefix  = req.rule_prefix;
	end

	// A check enters the head of the row with an empty decision.
	always_comb begin
		tok[0].valid     = accept && (req.command == CMD_CHECK) && security_q;
		tok[0].conn      = req.conn_kind;
		tok[0].addr      = req.client_address;
		tok[0].deny_hit  = 1'b0;
		tok[0].deny_at   = '0;
		tok[0].allow_hit = 1'b0;
		tok[0].allow_at  = '0;
		tok[0].has_allow = 1'b0;
		tok[0].has_deny  = 1'b0;
		tok[0].allows    = '0;
		tok[0].denies    = '0;
		used[0]          = used_sat;
	end

	for (genvar i = 0; i < RULE_DEPTH; i++) begin : g_cell
		cadc_cell #(
			.CELL_INDEX(i),
			.CNT_W     (CNT_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (wr),
			.tok_in  (tok[i]),
			.used_in (used[i]),
			.tok_out (tok[i+1]),
			.used_out(used[i+1])
		);
	end

	// Final decision once the token leaves the last cell.
	always_comb begin
		tail_result.allow_count   = tok[RULE_DEPTH].allows;
		tail_result.deny_count    = tok[RULE_DEPTH].denies;
		tail_result.matched_index = '0;
		priority if (tok[RULE_DEPTH].deny_hit) begin
			tail_result.verdict       = VERDICT_DENY;
			tail_result.matched_index = tok[RULE_DEPTH].deny_at;
		end else if (tok[RULE_DEPTH].allow_hit) begin
			tail_result.verdict       = VERDICT_ADMIT;
			tail_result.matched_index = tok[RULE_DEPTH].allow_at;
		end else if (tok[RULE_DEPTH].has_allow || !tok[RULE_DEPTH].has_deny) begin
			tail_result.verdict = VERDICT_NOT_ALLOWED;
		end else begin
			tail_result.verdict = VERDICT_ADMIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			done_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end
			if ((accept && direct) || tok[RULE_DEPTH].valid) begin
				done_valid_q <= 1'b1;
			end
			if (done_valid_q && (!out_valid_q || rsp.ready)) begin
				done_valid_q <= 1'b0;
				busy_q       <= 1'b0;
				out_valid_q  <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && direct) begin
			done_q.verdict       <= (req.command == CMD_WRITE) ? VERDICT_WRITTEN : VERDICT_ADMIT;
			done_q.matched_index <= '0;
			done_q.allow_count   <= '0;
			done_q.deny_count    <= '0;
		end else if (tok[RULE_DEPTH].valid) begin
			done_q <= tail_result;
		end
		if (done_valid_q && (!out_valid_q || rsp.ready)) begin
			out_q <= done_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.verdict       = out_q.verdict;
	assign rsp.matched_index = out_q.matched_index;
	assign rsp.allow_count   = out_q.allow_count;
	assign rsp.deny_count    = out_q.deny_count;

endmodule

`default_nettype wire

>>> dv/tb.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cadc_pkg::*;

	localparam int DEPTH = 16;

	// Rule kinds that the checker skips, and connection kinds that match no rule.
	localparam logic [1:0] KIND_IGNORED  = 2'd2;
	localparam logic [1:0] KIND_RESERVED = 2'd3;
	localparam logic [1:0] CONN_UNKNOWN  = 2'd0;
	localparam logic [1:0] CONN_OTHER    = 2'd3;

	// Random items to offer after the directed part; the last phase may run past it.
	localparam int RANDOM_ITEMS = 1150;

	// One request item as the testbench holds it: a rule write or a check.
	typedef struct packed {
		logic                command;
		logic [IDX_W-1:0]    rule_index;
		rule_t               rule;
		logic [1:0]          conn_kind;
		logic [ADDR_W-1:0]   client_address;
	} request_t;

	// The scoreboard keeps its own copy of the rule entries and of both
	// configuration registers. Every accepted request is turned into the
	// result the checker must return, and results are matched in order.
	class acl_scoreboard;
		rule_t            entries[DEPTH];
		logic             security;
		logic [CFG_W-1:0] rules_used;
		result_t          awaited_verdicts[$];
		int unsigned      failures;
		int unsigned      writes_seen;
		int unsigned      checks_seen;
		int unsigned      admitted;
		int unsigned      denied;
		int unsigned      refused;

		function new();
			security   = 1'b0;
			rules_used = '0;
			failures   = 0;
			writes_seen = 0;
			checks_seen = 0;
			admitted   = 0;
			denied     = 0;
			refused    = 0;
		endfunction

		function void set_register(logic idx, logic [CFG_W-1:0] value);
			if (idx == REG_SECURITY) begin
				security = value[0];
			end else begin
				rules_used = value;
			end
		endfunction

		// Ones in the top bits covered by the prefix; lengths above 32 act as 32.
		function logic [ADDR_W-1:0] network_mask(logic [PREFIX_W-1:0] len);
			logic [63:0] ones;
			ones = 64'hFFFF_FFFF_0000_0000 >> ((len > FULL_PREFIX) ? FULL_PREFIX : len);
			return ones[31:0];
		endfunction

		function bit rule_hits(rule_t r, logic [1:0] conn, logic [ADDR_W-1:0] addr);
			logic want;
			if (conn == CONN_PLAY) begin
				want = ACTION_PLAY;
			end else if (conn == CONN_PUBLISH) begin
				want = ACTION_PUBLISH;
			end else begin
				return 1'b0;
			end
			if (r.action != want) begin
				return 1'b0;
			end
			return ((r.network ^ addr) & network_mask(r.prefix)) == '0;
		endfunction

		// Applies a write to the entry copy, or decides a check.
		function result_t decide_access(request_t it);
			result_t          outcome;
			int unsigned      span;
			int unsigned      n_allow;
			int unsigned      n_deny;
			bit               deny_found;
			bit               allow_found;
			logic [IDX_W-1:0] deny_slot;
			logic [IDX_W-1:0] allow_slot;
			outcome = '0;
			outcome.verdict = VERDICT_ADMIT;
			if (it.command == CMD_WRITE) begin
				entries[it.rule_index] = it.rule;
				outcome.verdict = VERDICT_WRITTEN;
				return outcome;
			end
			if (!security) begin
				return outcome;
			end
			span = (rules_used > DEPTH) ? DEPTH : rules_used;
			n_allow = 0;
			n_deny = 0;
			deny_found = 1'b0;
			allow_found = 1'b0;
			deny_slot = '0;
			allow_slot = '0;
			for (int i = 0; i < span; i++) begin
				if (entries[i].kind == KIND_DENY) begin
					n_deny++;
					if (!deny_found && rule_hits(entries[i], it.conn_kind, it.client_address)) begin
						deny_found = 1'b1;
						deny_slot = IDX_W'(i);
					end
				end else if (entries[i].kind == KIND_ALLOW) begin
					n_allow++;
					if (!allow_found && rule_hits(entries[i], it.conn_kind, it.client_address)) begin
						allow_found = 1'b1;
						allow_slot = IDX_W'(i);
					end
				end
			end
			if (deny_found) begin
				outcome.verdict = VERDICT_DENY;
				outcome.matched_index = deny_slot;
			end else if (allow_found) begin
				outcome.verdict = VERDICT_ADMIT;
				outcome.matched_index = allow_slot;
			end else if (n_allow > 0 || n_deny == 0) begin
				outcome.verdict = VERDICT_NOT_ALLOWED;
			end
			outcome.allow_count = COUNT_W'(n_allow);
			outcome.deny_count = COUNT_W'(n_deny);
			return outcome;
		endfunction

		function void note_request(request_t it);
			if (it.command == CMD_WRITE) begin
				writes_seen++;
			end else begin
				checks_seen++;
			end
			awaited_verdicts.push_back(decide_access(it));
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (awaited_verdicts.size() == 0) begin
				$error("result with nothing outstanding: verdict %0d", got.verdict);
				failures++;
				return;
			end
			want = awaited_verdicts.pop_front();
			case (want.verdict)
				VERDICT_ADMIT:       admitted++;
				VERDICT_DENY:        denied++;
				VERDICT_NOT_ALLOWED: refused++;
				default:             ;
			endcase
			if (got.verdict !== want.verdict) begin
				$error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
				failures++;
			end
			if (got.matched_index !== want.matched_index) begin
				$error("matched_index: expected %0d, got %0d", want.matched_index,
					got.matched_index);
				failures++;
			end
			if (got.allow_count !== want.allow_count) begin
				$error("allow_count: expected %0d, got %0d", want.allow_count, got.allow_count);
				failures++;
			end
			if (got.deny_count !== want.deny_count) begin
				$error("deny_count: expected %0d, got %0d", want.deny_count, got.deny_count);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	cadc_req_if req();
	cadc_rsp_if rsp();
	cadc_cfg_if cfg();

	cidr_allow_deny_checker #(
		.RULE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	acl_scoreboard acl = new();

	// Shared knobs: "steady" switches idling off on both sides for one phase,
	// and "choke_pending" asks the receiver for one long hold-off.
	bit steady = 1'b0;
	bit choke_pending = 1'b0;
	int unsigned random_sent = 0;
	int unsigned settings_applied = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run. The slowest correct run stays below it, although
	// every check walks the whole row, every item waits out the
	// longest sender gap, and the receiver stalls on top of that.
	initial begin
		#3ms;
		$display("== FAIL ==");
		$finish;
	end

	// The receiver. It drops ready in about a quarter of the cycles, except in
	// the steady phase. On request it holds ready low for a long stretch, which
	// it counts itself, so that the checker fills up and refuses new items.
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (choke_pending) begin
				choke_pending = 1'b0;
				rsp.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				rsp.ready <= arst_n && (steady || $urandom_range(99) >= 23);
			end
		end
	end

	// Every result transfer is compared with the oldest prediction. Values are
	// read right at the edge, before any assignment of that edge has landed.
	always @(posedge clk) begin : watch_results
		result_t seen;
		if (arst_n && rsp.valid && rsp.ready) begin
			seen.verdict = verdict_t'(rsp.verdict);
			seen.matched_index = rsp.matched_index;
			seen.allow_count = rsp.allow_count;
			seen.deny_count = rsp.deny_count;
			acl.check_result(seen);
		end
	end

	// Offers one item and returns at the edge that transfers it. When the
	// next item follows at once, valid simply stays high.
	task automatic drive_item(input request_t it);
		req.valid <= 1'b1;
		req.command <= it.command;
		req.rule_index <= it.rule_index;
		req.rule_kind <= it.rule.kind;
		req.rule_action <= it.rule.action;
		req.rule_network <= it.rule.network;
		req.rule_prefix <= it.rule.prefix;
		req.conn_kind <= it.conn_kind;
		req.client_address <= it.client_address;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		acl.note_request(it);
	endtask

	// Sender side idling: a short random gap ahead of about a quarter of the
	// items, none in the steady phase.
	task automatic send(input request_t it);
		if (!steady && $urandom_range(99) < 23) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		drive_item(it);
	endtask

	// Lowers valid and waits until every predicted result has come back, so
	// the checker is idle. It always waits for a clock edge, so a following
	// item never sees valid lowered and raised within one step.
	task automatic finish_batch();
		req.valid <= 1'b0;
		do @(posedge clk); while (acl.awaited_verdicts.size() != 0);
	endtask

	// Writes both registers back to back. The security word carries random
	// upper bits, which the checker must ignore.
	task automatic apply_settings(input logic enable, input logic [CFG_W-1:0] used);
		logic [CFG_W-1:0] word;
		word = CFG_W'($urandom);
		word[0] = enable;
		cfg.valid <= 1'b1;
		cfg.index <= REG_SECURITY;
		cfg.data <= word;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		acl.set_register(REG_SECURITY, word);
		cfg.index <= REG_RULES;
		cfg.data <= used;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		acl.set_register(REG_RULES, used);
		cfg.valid <= 1'b0;
		settings_applied++;
	endtask

	// A rule write; the check fields carry noise, which the checker must ignore.
	function automatic request_t make_write(input logic [IDX_W-1:0] idx,
			input logic [1:0] kind, input logic action, input logic [ADDR_W-1:0] net,
			input logic [PREFIX_W-1:0] len);
		request_t it;
		it.command = CMD_WRITE;
		it.rule_index = idx;
		it.rule.kind = kind;
		it.rule.action = action;
		it.rule.network = net;
		it.rule.prefix = len;
		it.conn_kind = 2'($urandom);
		it.client_address = $urandom;
		return it;
	endfunction

	// A check; the rule fields carry noise.
	function automatic request_t make_check(input logic [1:0] conn,
			input logic [ADDR_W-1:0] addr);
		request_t it;
		it.command = CMD_CHECK;
		it.rule_index = IDX_W'($urandom);
		it.rule.kind = 2'($urandom);
		it.rule.action = 1'($urandom);
		it.rule.network = $urandom;
		it.rule.prefix = PREFIX_W'($urandom);
		it.conn_kind = conn;
		it.client_address = addr;
		return it;
	endfunction

	// Random item. Most are checks, most of them aimed at a stored rule: the
	// address keeps the rule's network bits and randomizes the rest, sometimes
	// with one random bit flipped, which may land it just outside. The
	// connection kind usually fits the rule's action. The rest are random rule writes.
	function automatic request_t random_request();
		request_t              it;
		rule_t                 src;
		logic [ADDR_W-1:0]     mask;
		logic [ADDR_W-1:0]     addr;
		logic [1:0]            kind;
		logic [1:0]            conn;
		int unsigned           span;
		int unsigned           roll;
		roll = $urandom_range(99);
		if (roll < 20) begin
			roll = $urandom_range(9);
			kind = (roll < 4) ? KIND_ALLOW : (roll < 8) ? KIND_DENY :
				(roll == 8) ? KIND_IGNORED : KIND_RESERVED;
			return make_write(IDX_W'($urandom_range(DEPTH - 1)), kind, 1'($urandom),
				$urandom, ($urandom_range(9) < 7) ? PREFIX_W'($urandom_range(32)) :
				PREFIX_W'($urandom_range(33, 63)));
		end
		span = (acl.rules_used == 0) ? DEPTH : (acl.rules_used > DEPTH) ? DEPTH :
			acl.rules_used;
		src = acl.entries[$urandom_range(span - 1)];
		mask = acl.network_mask(src.prefix);
		if ($urandom_range(9) < 7) begin
			addr = (src.network & mask) | ($urandom & ~mask);
			if ($urandom_range(4) == 0) begin
				addr[$urandom_range(ADDR_W - 1)] ^= 1'b1;
			end
		end else begin
			addr = $urandom;
		end
		roll = $urandom_range(19);
		if (roll < 14) begin
			conn = (src.action == ACTION_PUBLISH) ? CONN_PUBLISH : CONN_PLAY;
		end else if (roll < 18) begin
			conn = (src.action == ACTION_PUBLISH) ? CONN_PLAY : CONN_PUBLISH;
		end else begin
			conn = (roll == 18) ? CONN_UNKNOWN : CONN_OTHER;
		end
		it = make_check(conn, addr);
		return it;
	endfunction

	initial begin
		logic [CFG_W-1:0] used;
		int unsigned      phase;
		int unsigned      batch;
		int unsigned      roll;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.command = CMD_WRITE;
		req.rule_index = '0;
		req.rule_kind = KIND_ALLOW;
		req.rule_action = ACTION_PLAY;
		req.rule_network = '0;
		req.rule_prefix = '0;
		req.conn_kind = CONN_UNKNOWN;
		req.client_address = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_SECURITY;
		cfg.data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset security is off, so a check is admitted without looking
		// at the rule entries, none of which have been written yet.
		send(make_check(CONN_PLAY, 32'h0000_0000));
		finish_batch();

		// Security on with no entries in use: an empty list refuses everything.
		// The entries are then filled, covering both rule kinds, the ignored
		// kinds, both actions, prefix "all", exact and oversized prefixes and
		// the network extremes.
		apply_settings(1'b1, 5'd0);
		send(make_check(CONN_OTHER, 32'hFFFF_FFFF));
		send(make_write(4'd0, KIND_DENY, ACTION_PUBLISH, 32'h0A00_0000, 6'd8));
		send(make_write(4'd1, KIND_IGNORED, ACTION_PLAY, 32'h0000_0000, 6'd0));
		send(make_write(4'd2, KIND_ALLOW, ACTION_PLAY, 32'hC0A8_0100, 6'd24));
		send(make_write(4'd3, KIND_RESERVED, ACTION_PUBLISH, 32'hFFFF_FFFF, 6'd63));
		send(make_write(4'd4, KIND_ALLOW, ACTION_PUBLISH, 32'hFFFF_FFFF, 6'd32));
		send(make_write(4'd5, KIND_DENY, ACTION_PLAY, 32'h0000_0000, 6'd40));
		send(make_write(4'd6, KIND_ALLOW, ACTION_PLAY, 32'hC0A8_0000, 6'd16));
		send(make_write(4'd7, KIND_DENY, ACTION_PLAY, 32'hAC10_0000, 6'd12));
		for (int i = 8; i < DEPTH; i++) begin
			send(make_write(IDX_W'(i), 2'(i % 4), 1'(i % 2), {4'(i), 28'h5A5_A5A5},
				PREFIX_W'((i * 7) % 64)));
		end
		finish_batch();

		// Only a deny rule and an ignored rule in use: a miss is admitted.
		apply_settings(1'b1, 5'd2);
		send(make_check(CONN_PUBLISH, 32'h0A01_0203));
		send(make_check(CONN_PUBLISH, 32'h0B00_0000));
		send(make_check(CONN_PLAY, 32'h0A01_0203));
		finish_batch();

		// A count above the depth saturates to the whole list.
		apply_settings(1'b1, 5'd31);
		send(make_check(CONN_PLAY, 32'hC0A8_014D));
		send(make_check(CONN_PLAY, 32'h0000_0000));
		send(make_check(CONN_PUBLISH, 32'hFFFF_FFFF));
		send(make_check(CONN_UNKNOWN, 32'hC0A8_014D));
		send(make_check(CONN_PLAY, 32'hAC1F_0001));
		finish_batch();

		// Security off again with every entry in use.
		apply_settings(1'b0, 5'd16);
		send(make_check(CONN_PUBLISH, 32'h0A00_0001));
		finish_batch();

		// Random phases, each with its own settings. Phase two runs with no
		// idling on either side; phase four has the receiver hold off while
		// the sender keeps offering items.
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			roll = $urandom_range(5);
			used = (roll == 0) ? 5'd0 : (roll == 1) ? 5'd16 : (roll == 2) ? 5'd31 :
				CFG_W'($urandom_range(31));
			apply_settings($urandom_range(7) != 0, used);
			steady = (phase == 2);
			if (phase == 4) begin
				choke_pending = 1'b1;
			end
			batch = (phase == 2) ? 60 : $urandom_range(20, 60);
			for (int n = 0; n < batch; n++) begin
				send(random_request());
				random_sent++;
			end
			finish_batch();
			steady = 1'b0;
			phase++;
		end

		// Let a late or duplicate result show up before the verdict.
		repeat (DEPTH + 8) @(posedge clk);
		$display("Covered %0d rule writes and %0d checks under %0d register settings.",
			acl.writes_seen, acl.checks_seen, settings_applied);
		$display("Checks admitted %0d, denied by a rule %0d, refused for lack of an allow %0d.",
			acl.admitted, acl.denied, acl.refused);
		if (acl.failures == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
src/cadc_pkg.sv
src/cadc_if.sv
src/cadc_cell.sv
src/cidr_allow_deny_checker.sv
dv/tb.sv
